// File: hdl/mesh_uv_grid_generator_core_assert.svh
// Assertion macros used by the checker module of the mesh UV grid generator.
`ifndef MESH_UV_GRID_GENERATOR_CORE_ASSERT_SVH
`define MESH_UV_GRID_GENERATOR_CORE_ASSERT_SVH

// Concurrent assertion that is switched off while the reset is active.
`define MUGG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mugg assertion failed");

// Concurrent assertion that also holds during reset.
`define MUGG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mugg assertion failed");

`endif

// File: hdl/mugg_pkg.sv
// Package with the constants and types of the mesh UV grid generator.
`default_nettype none
package mugg_pkg;

    localparam int FRAC_SHIFT  = 8;
    localparam int MAX_GRID    = 7;
    localparam int COORD_BITS  = 12;
    localparam int GRID_W      = 3;
    localparam int OUT_W       = 20;
    localparam int SUM_W       = 24;

    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES  = SUM_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    typedef logic [COORD_BITS-1:0] t_pix;
    typedef logic [GRID_W-1:0]     t_grid;
    typedef logic [OUT_W-1:0]      t_coord;
    typedef logic [SUM_W-1:0]      t_sum;

    typedef struct packed {
        logic   err;
        t_coord left_edge;
        t_coord top_edge;
        t_coord right_edge;
        t_coord bottom_edge;
        t_grid  cols;
        t_grid  rows;
    } t_job;

    typedef struct packed {
        t_sum  dividend;
        t_grid divisor;
    } t_div_req;

endpackage
`default_nettype wire

// File: hdl/mugg_front.sv
// Front end: accepts grid requests, checks the crop and forms the edge descriptor.
`default_nettype none
module mugg_front (
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [mugg_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output mugg_pkg::t_job                        o_job
);

    mugg_pkg::t_pix  iw, ih, cx, cy, cw, ch;
    mugg_pkg::t_grid gc, gr, cols, rows;
    logic [mugg_pkg::COORD_BITS:0] sum_x, sum_y;
    mugg_pkg::t_pix  ew, eh, rx, by;
    logic err_x, err_y;

    always_comb begin
        iw = i_s_tdata[11:0];
        ih = i_s_tdata[23:12];
        cx = i_s_tdata[35:24];
        cy = i_s_tdata[47:36];
        cw = i_s_tdata[59:48];
        ch = i_s_tdata[71:60];
        gc = i_s_tdata[74:72];
        gr = i_s_tdata[77:75];

        sum_x = {1'b0, cx} + {1'b0, cw};
        sum_y = {1'b0, cy} + {1'b0, ch};
        err_x = (cw != '0) ? (sum_x > {1'b0, iw}) : (cx >= iw);
        err_y = (ch != '0) ? (sum_y > {1'b0, ih}) : (cy >= ih);
        ew = (cw != '0) ? cw : mugg_pkg::t_pix'(iw - cx);
        eh = (ch != '0) ? ch : mugg_pkg::t_pix'(ih - cy);
        rx = mugg_pkg::t_pix'(cx + ew - mugg_pkg::t_pix'(1));
        by = mugg_pkg::t_pix'(cy + eh - mugg_pkg::t_pix'(1));

        cols = (gc == '0) ? mugg_pkg::t_grid'(1) : gc;
        rows = (gr == '0) ? mugg_pkg::t_grid'(1) : gr;
        if (cols > mugg_pkg::t_grid'(mugg_pkg::MAX_GRID)) begin
            cols = mugg_pkg::t_grid'(mugg_pkg::MAX_GRID);
        end
        if (rows > mugg_pkg::t_grid'(mugg_pkg::MAX_GRID)) begin
            rows = mugg_pkg::t_grid'(mugg_pkg::MAX_GRID);
        end

        o_job = '0;
        if (err_x || err_y) begin
            o_job.err = 1'b1;
        end else begin
            o_job.left_edge   = mugg_pkg::t_coord'(cx) << mugg_pkg::FRAC_SHIFT;
            o_job.top_edge    = mugg_pkg::t_coord'(cy) << mugg_pkg::FRAC_SHIFT;
            o_job.right_edge  = mugg_pkg::t_coord'(rx) << mugg_pkg::FRAC_SHIFT;
            o_job.bottom_edge = mugg_pkg::t_coord'(by) << mugg_pkg::FRAC_SHIFT;
            o_job.cols        = cols;
            o_job.rows        = rows;
        end
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

endmodule
`default_nettype wire

// File: hdl/mugg_queue.sv
// Short job queue between the front end and the point generator.
`default_nettype none
module mugg_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mugg_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output mugg_pkg::t_job      o_job,
    output logic                o_empty
);

    mugg_pkg::t_job r_mem [mugg_pkg::QUEUE_DEPTH];
    logic [mugg_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [mugg_pkg::QCNT_W-1:0] r_count;

    assign o_full  = (r_count == mugg_pkg::QCNT_W'(mugg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/mugg_div.sv
// Iterative restoring divider, two quotient bits per cycle, small divisor.
`default_nettype none
module mugg_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire mugg_pkg::t_div_req i_req,
    output logic                    o_done,
    output mugg_pkg::t_sum          o_quotient
);

    mugg_pkg::t_sum  r_quo, n_quo;
    mugg_pkg::t_grid r_rem, n_rem;
    mugg_pkg::t_grid r_div;
    logic [mugg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic r_run, r_done;
    logic [mugg_pkg::GRID_W:0] trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < mugg_pkg::DIV_BITS_PER_CYCLE; k++) begin
            trial = {n_rem, n_quo[mugg_pkg::SUM_W-1]};
            n_quo = {n_quo[mugg_pkg::SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem    = mugg_pkg::t_grid'(trial - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[mugg_pkg::GRID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_run) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == mugg_pkg::DIV_CNT_W'(mugg_pkg::DIV_CYCLES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// File: hdl/mugg_back.sv
// Back end: walks the grid, interpolates each point and holds it in the output register.
`default_nettype none
module mugg_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_empty,
    input  wire mugg_pkg::t_job                    i_job,
    output logic                                   o_pop,
    output logic                                   o_div_start,
    output mugg_pkg::t_div_req                     o_div_req,
    input  wire logic                              i_div_done,
    input  wire mugg_pkg::t_sum                    i_div_quotient,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [mugg_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                   o_m_tlast,
    output logic                                   o_m_tuser
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STARTY = 3'd1;
    localparam logic [2:0] S_WAITY  = 3'd2;
    localparam logic [2:0] S_STARTX = 3'd3;
    localparam logic [2:0] S_WAITX  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state;
    mugg_pkg::t_job   r_job;
    mugg_pkg::t_grid  r_row, r_col;
    mugg_pkg::t_coord r_y, r_x_out, r_y_out;
    logic r_last, r_err;
    logic y_sel;
    mugg_pkg::t_coord a_edge, b_edge;
    mugg_pkg::t_grid  pos, cnt;

    always_comb begin
        y_sel  = (r_state == S_STARTY);
        a_edge = y_sel ? r_job.top_edge : r_job.left_edge;
        b_edge = y_sel ? r_job.bottom_edge : r_job.right_edge;
        pos    = y_sel ? r_row : r_col;
        cnt    = y_sel ? r_job.rows : r_job.cols;
        o_div_req.dividend = mugg_pkg::t_sum'(a_edge) * mugg_pkg::t_sum'(cnt - pos)
                           + mugg_pkg::t_sum'(b_edge) * mugg_pkg::t_sum'(pos);
        o_div_req.divisor  = cnt;
    end

    assign o_div_start = (r_state == S_STARTY) || (r_state == S_STARTX);
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_m_tdata   = {r_y_out, r_x_out};
    assign o_m_tlast   = r_last;
    assign o_m_tuser   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_row <= '0;
                        r_col <= '0;
                        if (i_job.err) begin
                            r_x_out <= '0;
                            r_y_out <= '0;
                            r_last  <= 1'b1;
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_STARTY;
                        end
                    end
                end
                S_STARTY: r_state <= S_WAITY;
                S_WAITY: begin
                    if (i_div_done) begin
                        r_y     <= mugg_pkg::t_coord'(i_div_quotient);
                        r_state <= S_STARTX;
                    end
                end
                S_STARTX: r_state <= S_WAITX;
                S_WAITX: begin
                    if (i_div_done) begin
                        r_x_out <= mugg_pkg::t_coord'(i_div_quotient);
                        r_y_out <= r_y;
                        r_last  <= (r_row == r_job.rows) && (r_col == r_job.cols);
                        r_err   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else if (r_col == r_job.cols) begin
                            r_col   <= '0;
                            r_row   <= r_row + 1'b1;
                            r_state <= S_STARTY;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_STARTX;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/mesh_uv_grid_generator_core.sv
// Top level of the mesh UV grid generator: front end, job queue, divider and point walker.
// Order: a crop error result goes from the queue straight to the output register; the first
// point of a grid follows its y and x divisions, which run back to back on one divider.
// Each point waits for its x division, and each new grid row also for its y division; a grid
// gives (cols+1)*(rows+1) points, and the queue holds two jobs while the walker is busy.
// Reset: synchronous, active low; it empties the queue and idles the walker and divider.
`default_nettype none
module mesh_uv_grid_generator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // img_width[11:0], img_height[23:12], crop_x[35:24], crop_y[47:36],
    // crop_w[59:48], crop_h[71:60], grid_cols[74:72], grid_rows[77:75], zero[79:78]
    input  wire logic [mugg_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // x_q8[19:0], y_q8[39:20]
    output logic [mugg_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                   o_m_tlast,
    // crop_error[0]
    output logic                                   o_m_tuser
);

    logic full, empty, push, pop, div_start, div_done;
    mugg_pkg::t_job     front_job, queue_job;
    mugg_pkg::t_div_req div_req;
    mugg_pkg::t_sum     div_quotient;

    mugg_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (full),
        .o_push     (push),
        .o_job      (front_job)
    );

    mugg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty)
    );

    mugg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    mugg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (queue_job),
        .o_pop          (pop),
        .o_div_start    (div_start),
        .o_div_req      (div_req),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata),
        .o_m_tlast      (o_m_tlast),
        .o_m_tuser      (o_m_tuser)
    );

endmodule
`default_nettype wire

// File: hdl/mugg_checker.sv
// Port-level assertion checker for the mesh UV grid generator, bound to the top level.
`default_nettype none
`include "mesh_uv_grid_generator_core_assert.svh"
module mugg_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [mugg_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input wire logic                              o_m_tlast,
    input wire logic                              o_m_tuser
);

    `MUGG_ASSERT(a_err_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tlast)
    `MUGG_ASSERT(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> (o_m_tdata == '0))
    `MUGG_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
    `MUGG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind mesh_uv_grid_generator_core mugg_checker u_mugg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
